@@ hdl/pie_pkg.sv @@
// Package for the positional insert/extract list: depth, widths, opcodes,
// request/result structs and the per-cycle cell command struct.
// No dependencies.
package pie_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int OP_W     = 3;
    localparam int POS_W    = 16;
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT  = 3'd0,
        OP_PUSH_BACK   = 3'd1,
        OP_INSERT      = 3'd2,
        OP_EXTRACT_HD  = 3'd3,
        OP_EXTRACT_TL  = 3'd4,
        OP_EXTRACT_IDX = 3'd5,
        OP_READ        = 3'd6,
        OP_WRITE       = 3'd7
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic signed [POS_W-1:0]   position;
        logic signed [WORD_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  result_value;
        logic                      ok;
        logic                      dropped_full;
        logic [LEN_W-1:0]          length;
    } rsp_t;

    // Command broadcast to every cell in the row.
    typedef struct packed {
        logic                      ins;   // open a slot at idx, shift tail right
        logic                      rem;   // close slot at idx, shift tail left
        logic                      wr;    // overwrite slot idx
        logic [IDX_W-1:0]          idx;
        logic [WORD_W-1:0]         word;
    } cell_cmd_t;

endpackage

@@ hdl/positional_insert_extract_list.sv @@
// Positional insert/extract list, top level: a row of word cells shifted in
// parallel, a request decoder and a result register.
// Depends on pie_pkg, pie_decode and pie_cell.
//
// Throughput: one request per cycle, also while a result waits on m_ready
//   whenever that result is taken in the same cycle.
// Timing: the result is registered, valid in the cycle after the request is
//   accepted; the cell row shift is registered at the same edge as the result.
// Reset: aresetn (synchronous, active low) empties the list and the result
//   register; stored words are not cleared, cells past the count are never read.
module positional_insert_extract_list (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pie_pkg::req_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output pie_pkg::rsp_t    m_data
);
    import pie_pkg::*;

    // list occupancy
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // result register
    logic               m_valid_reg;
    logic               m_valid_next;
    rsp_t               m_data_reg;
    rsp_t               m_data_next;

    // decoder outputs
    cell_cmd_t          cmd;
    logic               rd;
    logic               ok;
    logic               dropped_full;
    logic               fire;

    // cell row
    logic [WORD_W-1:0]  entry [DEPTH];

    // A new request can enter when the result slot is empty or being drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;

    pie_decode u_decode (
        .fire         (fire),
        .req          (s_data),
        .count        (count_reg),
        .cmd          (cmd),
        .rd           (rd),
        .ok           (ok),
        .dropped_full (dropped_full),
        .count_next   (count_next)
    );

    // Cell i takes cell i-1 on insert and cell i+1 on remove; cell 0's left input
    // is never selected, and the last cell takes its own word back on a remove.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = cmd.word;
        end else begin : g_mid_l
            assign left_w = entry[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = entry[i];
        end else begin : g_mid_r
            assign right_w = entry[i+1];
        end

        pie_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .cell_idx    (IDX_W'(i)),
            .entry_left  (left_w),
            .entry_right (right_w),
            .entry_q     (entry[i])
        );
    end

    // Result: read/extract word comes from the addressed cell before the shift.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (fire) begin
            m_valid_next              = 1'b1;
            m_data_next.result_value  = rd ? entry[cmd.idx] : '0;
            m_data_next.ok            = ok;
            m_data_next.dropped_full  = dropped_full;
            m_data_next.length        = LEN_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ hdl/pie_cell.sv @@
// One storage cell of the list row: holds one word and takes its left or
// right neighbor's word on a shift. Depends on pie_pkg.
module pie_cell (
    input  logic                          aclk,
    input  pie_pkg::cell_cmd_t            cmd,
    input  logic [pie_pkg::IDX_W-1:0]     cell_idx,
    input  logic [pie_pkg::WORD_W-1:0]    entry_left,
    input  logic [pie_pkg::WORD_W-1:0]    entry_right,
    output logic [pie_pkg::WORD_W-1:0]    entry_q
);
    import pie_pkg::*;

    logic [WORD_W-1:0] entry_reg;
    logic [WORD_W-1:0] entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins) begin
            if (cell_idx > cmd.idx) begin
                entry_next = entry_left;
            end else if (cell_idx == cmd.idx) begin
                entry_next = cmd.word;
            end
        end else if (cmd.rem) begin
            if (cell_idx >= cmd.idx) begin
                entry_next = entry_right;
            end
        end else if (cmd.wr) begin
            if (cell_idx == cmd.idx) begin
                entry_next = cmd.word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;

endmodule

@@ hdl/pie_decode.sv @@
// Request decoder: turns opcode, position and count into the cell command,
// status flags and next count. Depends on pie_pkg.
module pie_decode (
    input  logic                       fire,
    input  pie_pkg::req_t              req,
    input  logic [pie_pkg::CNT_W-1:0]  count,
    output pie_pkg::cell_cmd_t         cmd,
    output logic                       rd,
    output logic                       ok,
    output logic                       dropped_full,
    output logic [pie_pkg::CNT_W-1:0]  count_next
);
    import pie_pkg::*;

    logic              full;
    logic              pos_neg;
    logic [POS_W-1:0]  pos_u;
    logic [POS_W-1:0]  cnt_ext;
    logic              in_range;
    logic              ins_range;
    logic [IDX_W-1:0]  pos_idx;
    logic [IDX_W-1:0]  tail_idx;
    logic [IDX_W-1:0]  back_idx;

    assign full      = (count == CNT_W'(DEPTH));
    assign pos_neg   = req.position[POS_W-1];
    assign pos_u     = POS_W'(req.position[POS_W-2:0]);
    assign cnt_ext   = POS_W'(count);
    assign in_range  = !pos_neg && (pos_u < cnt_ext);
    assign ins_range = !pos_neg && (pos_u <= cnt_ext);
    assign pos_idx   = req.position[IDX_W-1:0];
    assign back_idx  = count[IDX_W-1:0];
    assign tail_idx  = IDX_W'(count - 1'b1);

    always_comb begin
        cmd          = '0;
        cmd.word     = req.value;
        rd           = 1'b0;
        ok           = 1'b0;
        dropped_full = 1'b0;
        unique case (req.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                cmd.idx = (req.op == OP_PUSH_FRONT) ? '0 : back_idx;
                if (full) begin
                    dropped_full = 1'b1;
                end else begin
                    cmd.ins = 1'b1;
                    ok      = 1'b1;
                end
            end
            OP_INSERT: begin
                cmd.idx = pos_idx;
                if (ins_range) begin
                    if (full) begin
                        dropped_full = 1'b1;
                    end else begin
                        cmd.ins = 1'b1;
                        ok      = 1'b1;
                    end
                end
            end
            OP_EXTRACT_HD, OP_EXTRACT_TL: begin
                cmd.idx = (req.op == OP_EXTRACT_HD) ? '0 : tail_idx;
                if (count != '0) begin
                    cmd.rem = 1'b1;
                    rd      = 1'b1;
                    ok      = 1'b1;
                end
            end
            OP_EXTRACT_IDX: begin
                cmd.idx = pos_idx;
                if (in_range) begin
                    cmd.rem = 1'b1;
                    rd      = 1'b1;
                    ok      = 1'b1;
                end
            end
            OP_READ, OP_WRITE: begin
                if (req.op == OP_READ) begin
                    cmd.word = '0;
                end
                if (in_range) begin
                    cmd.idx = pos_idx;
                    cmd.wr  = (req.op == OP_WRITE);
                    rd      = (req.op == OP_READ);
                    ok      = 1'b1;
                end else begin
                    // auto-grow: negative index fills the front, else the back
                    cmd.idx = pos_neg ? '0 : back_idx;
                    if (full) begin
                        dropped_full = 1'b1;
                    end else begin
                        cmd.ins = 1'b1;
                        ok      = 1'b1;
                    end
                end
            end
            default: begin
                cmd = '0;
            end
        endcase

        if (!fire) begin
            cmd.ins = 1'b0;
            cmd.rem = 1'b0;
            cmd.wr  = 1'b0;
        end

        if (cmd.ins) begin
            count_next = count + 1'b1;
        end else if (cmd.rem) begin
            count_next = count - 1'b1;
        end else begin
            count_next = count;
        end
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Testbench for positional_insert_extract_list: random and directed list requests,
// with expected results predicted by a scoreboard class. Depends on pie_pkg and positional_insert_extract_list.
module tb;
    import pie_pkg::*;

    // Depth-bounded list that mirrors the block and queues the result due for
    // each accepted request.
    class list_tracker;
        logic signed [WORD_W-1:0] words[DEPTH];
        int                       used;
        rsp_t                     due_results[$];
        int                       errors;

        function new();
            used   = 0;
            errors = 0;
        endfunction

        function int count();
            return used;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Open a slot at pos and shift the tail back; refused when full or past the end.
        function bit add_at(int pos, logic signed [WORD_W-1:0] w);
            int i;
            if (used >= DEPTH || pos > used) begin
                return 1'b0;
            end
            for (i = used; i > pos; i--) begin
                words[i] = words[i-1];
            end
            words[pos] = w;
            used++;
            return 1'b1;
        endfunction

        // Take the word at pos out and close the gap.
        function logic signed [WORD_W-1:0] take_at(int pos);
            logic signed [WORD_W-1:0] w;
            int                       i;
            w = words[pos];
            for (i = pos; i + 1 < used; i++) begin
                words[i] = words[i+1];
            end
            used--;
            return w;
        endfunction

        function void note_req(req_t r);
            rsp_t e;
            int   pos;
            bit   hit;
            e   = '0;
            pos = int'($signed(r.position));
            hit = (pos >= 0) && (pos < used);
            case (r.op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    e.ok           = add_at((r.op == OP_PUSH_FRONT) ? 0 : used, r.value);
                    e.dropped_full = !e.ok;
                end
                OP_INSERT: begin
                    if (pos >= 0 && pos <= used) begin
                        e.ok           = add_at(pos, r.value);
                        e.dropped_full = !e.ok;
                    end
                end
                OP_EXTRACT_HD: begin
                    if (used > 0) begin
                        e.result_value = take_at(0);
                        e.ok           = 1'b1;
                    end
                end
                OP_EXTRACT_TL: begin
                    if (used > 0) begin
                        e.result_value = take_at(used - 1);
                        e.ok           = 1'b1;
                    end
                end
                OP_EXTRACT_IDX: begin
                    if (hit) begin
                        e.result_value = take_at(pos);
                        e.ok           = 1'b1;
                    end
                end
                default: begin
                    // read / write: in range touches the slot, otherwise the list grows
                    if (hit) begin
                        if (r.op == OP_WRITE) begin
                            words[pos] = r.value;
                        end else begin
                            e.result_value = words[pos];
                        end
                        e.ok = 1'b1;
                    end else begin
                        e.ok = add_at((pos < 0) ? 0 : used,
                                      (r.op == OP_WRITE) ? r.value : '0);
                        e.dropped_full = !e.ok;
                    end
                end
            endcase
            e.length = LEN_W'(used);
            due_results.insert(due_results.size(), e);
        endfunction

        function void check_rsp(rsp_t got);
            rsp_t e;
            if (due_results.size() == 0) begin
                $error("result with no request outstanding: %p", got);
                errors++;
                return;
            end
            e = due_results.pop_front();
            if (got.result_value !== e.result_value) begin
                $error("result_value: expected %0d, got %0d", e.result_value, got.result_value);
                errors++;
            end
            if (got.ok !== e.ok) begin
                $error("ok: expected %0b, got %0b", e.ok, got.ok);
                errors++;
            end
            if (got.dropped_full !== e.dropped_full) begin
                $error("dropped_full: expected %0b, got %0b", e.dropped_full, got.dropped_full);
                errors++;
            end
            if (got.length !== e.length) begin
                $error("length: expected %0d, got %0d", e.length, got.length);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 1000;  // cycles with no handshake before giving up
    localparam int LONG_HOLD   = 80;    // receiver hold-off, well past the result register
    localparam int N_CHUNKS    = 13;
    localparam int CHUNK_LEN   = 50;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    req_t  s_data;
    logic  m_valid;
    logic  m_ready;
    rsp_t  m_data;

    list_tracker tracker = new();

    bit no_idle  = 1'b0;   // phase with back-to-back traffic on both sides
    bit hold_req = 1'b0;   // asks the receiver for one long hold-off
    int quiet_cycles = 0;

    positional_insert_extract_list u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 15));
    endfunction

    function automatic req_t mk_req(op_t op, int pos, logic signed [WORD_W-1:0] val);
        req_t r;
        r.op       = op;
        r.position = POS_W'(pos);
        r.value    = val;
        return r;
    endfunction

    // Offer one request after gap idle cycles and hold it until taken.
    // Valid is only lowered when a gap follows, so it never drops and rises in one step.
    task automatic send_req(req_t r, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_req(r);
    endtask

    task automatic wait_drain();
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    // Short directed pass: empty list, each op, boundary inserts, full list.
    task automatic run_directed();
        send_req(mk_req(OP_EXTRACT_HD, 0, 0), draw_gap());             // empty head
        send_req(mk_req(OP_EXTRACT_TL, 0, 0), draw_gap());             // empty tail
        send_req(mk_req(OP_READ, 3, 32'sh5a5a5a5a), draw_gap());       // read past end grows
        send_req(mk_req(OP_WRITE, -1, 32'sh7fffffff), draw_gap());     // negative write -> front
        send_req(mk_req(OP_PUSH_FRONT, 0, 32'sh80000000), draw_gap());
        send_req(mk_req(OP_PUSH_BACK, 0, 32'sh7fffffff), draw_gap());
        send_req(mk_req(OP_INSERT, 0, 1), draw_gap());                 // insert at front
        send_req(mk_req(OP_INSERT, tracker.count(), 2), draw_gap());   // insert at back
        send_req(mk_req(OP_INSERT, 2, -5), draw_gap());                // insert mid
        send_req(mk_req(OP_INSERT, 100, 7), draw_gap());               // bad index, ignored
        send_req(mk_req(OP_READ, 1, 0), draw_gap());
        send_req(mk_req(OP_WRITE, 0, -1), draw_gap());
        send_req(mk_req(OP_EXTRACT_IDX, 3, 0), draw_gap());
        send_req(mk_req(OP_EXTRACT_IDX, 32767, 0), draw_gap());        // bad index
        send_req(mk_req(OP_EXTRACT_TL, 0, 0), draw_gap());
        while (tracker.count() < DEPTH) begin
            send_req(mk_req(OP_PUSH_BACK, 0, $urandom), draw_gap());
        end
        // full list: every growing request is dropped
        send_req(mk_req(OP_PUSH_FRONT, 0, 9), draw_gap());
        send_req(mk_req(OP_INSERT, 3, 9), draw_gap());
        send_req(mk_req(OP_INSERT, -32768, 9), draw_gap());            // bad index, not dropped
        send_req(mk_req(OP_READ, DEPTH, 0), draw_gap());
        send_req(mk_req(OP_WRITE, -32768, 9), draw_gap());
    endtask

    // Ops weighted toward growing or shrinking so both full and empty are visited.
    function automatic op_t pick_op(bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (grow) begin
            if (r < 15)      return OP_PUSH_FRONT;
            else if (r < 30) return OP_PUSH_BACK;
            else if (r < 50) return OP_INSERT;
            else if (r < 65) return OP_WRITE;
            else if (r < 75) return OP_READ;
            else if (r < 83) return OP_EXTRACT_HD;
            else if (r < 91) return OP_EXTRACT_TL;
            else             return OP_EXTRACT_IDX;
        end else begin
            if (r < 5)       return OP_PUSH_FRONT;
            else if (r < 10) return OP_PUSH_BACK;
            else if (r < 20) return OP_INSERT;
            else if (r < 25) return OP_WRITE;
            else if (r < 35) return OP_READ;
            else if (r < 55) return OP_EXTRACT_HD;
            else if (r < 75) return OP_EXTRACT_TL;
            else             return OP_EXTRACT_IDX;
        end
    endfunction

    // Mostly in-range indexes; some just outside; a few fully random 16-bit values.
    function automatic req_t random_req(bit grow);
        req_t r;
        int   c;
        int   pick;
        int   pos;
        c    = tracker.count();
        r.op = pick_op(grow);
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            if (r.op == OP_INSERT)  pos = $urandom_range(0, c);
            else if (c > 0)         pos = $urandom_range(0, c - 1);
            else                    pos = 0;
        end else if (pick < 92) begin
            pos = int'($urandom_range(0, c + 6)) - 3;
        end else begin
            pos = $urandom_range(0, 65535);
        end
        r.position = POS_W'(pos);
        pick = $urandom_range(0, 9);
        if (pick == 0)      r.value = 32'sh80000000;
        else if (pick == 1) r.value = 32'sh7fffffff;
        else                r.value = $urandom;
        return r;
    endfunction

    task automatic run_random();
        int  chunk;
        int  n;
        bit  grow;
        for (chunk = 0; chunk < N_CHUNKS; chunk++) begin
            grow    = (chunk % 2 == 0);
            no_idle = (chunk % 4 == 3);
            // one chunk opens with a back-to-back burst against a stalled receiver
            if (chunk == 4) begin
                hold_req = 1'b1;
            end
            for (n = 0; n < CHUNK_LEN; n++) begin
                send_req(random_req(grow), (chunk == 4 && n < 30) ? 0 : draw_gap());
            end
            // sender pause: let every outstanding result come home
            if (chunk == 7) begin
                s_valid <= 1'b0;
                wait_drain();
            end
        end
        no_idle = 1'b0;
    endtask

    // Result side: random ready gaps, one long hold-off on request.
    initial begin
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                gap = LONG_HOLD;
            end else begin
                gap = draw_gap();
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            tracker.check_rsp(m_data);
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed pass, random pass, drain, verdict.
    initial begin
        s_valid <= 1'b0;
        s_data  <= '0;
        aresetn <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_random();
        s_valid <= 1'b0;
        wait_drain();
        // then idle on so that any stray result is caught before the verdict
        repeat (4) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/pie_pkg.sv
hdl/pie_cell.sv
hdl/pie_decode.sv
hdl/positional_insert_extract_list.sv
bench/tb.sv
